[sv/sba_pkg.sv]
// shared types, constants and register codes for the sprite blit alpha compositor
package sba_pkg;

    // fixed field widths
    localparam int SBA_ADDR_W   = 24;
    localparam int SBA_WORD_W   = 32;
    localparam int SBA_RUN_W    = 24;
    localparam int SBA_CFG_W    = 24;
    localparam int SBA_CFG_IDX_W = 3;
    localparam int SBA_ALPHA_W  = 9;
    localparam int SBA_SIZE_W   = 13;
    localparam int SBA_DSTR_W   = 13;
    localparam int SBA_SSTR_W   = 16;

    // parameter defaults
    localparam int SBA_MAX_SPAN = 4096;
    localparam int SBA_Q_DEPTH  = 2;

    // register indexes
    localparam logic [SBA_CFG_IDX_W-1:0] CFG_ALPHA_LEVEL = 3'd0;
    localparam logic [SBA_CFG_IDX_W-1:0] CFG_ROW_PIXELS  = 3'd1;
    localparam logic [SBA_CFG_IDX_W-1:0] CFG_ROW_COUNT   = 3'd2;
    localparam logic [SBA_CFG_IDX_W-1:0] CFG_DEST_START  = 3'd3;
    localparam logic [SBA_CFG_IDX_W-1:0] CFG_DEST_STRIDE = 3'd4;
    localparam logic [SBA_CFG_IDX_W-1:0] CFG_SRC_START   = 3'd5;
    localparam logic [SBA_CFG_IDX_W-1:0] CFG_SRC_STRIDE  = 3'd6;

    // register reset values
    localparam logic [SBA_ALPHA_W-1:0] SBA_ALPHA_RST = 9'd256;

    // pixel constants
    localparam logic [7:0]            SBA_SKIP_TAG = 8'hFF;
    localparam logic [SBA_WORD_W-1:0] SBA_NIB_MASK = 32'h000F0F0F;
    localparam logic [SBA_WORD_W-1:0] SBA_OPAQUE   = 32'hFF000000;
    localparam logic [7:0]            SBA_FULL8    = 8'hFF;

    // input item
    typedef struct packed {
        logic [SBA_WORD_W-1:0] src_word;
        logic [SBA_WORD_W-1:0] dest_word;
    } t_sba_in;

    // result item
    typedef struct packed {
        logic                  write_enable;
        logic [SBA_ADDR_W-1:0] write_address;
        logic [SBA_WORD_W-1:0] write_data;
        logic [SBA_ADDR_W-1:0] next_src_address;
        logic [SBA_ADDR_W-1:0] next_dest_address;
        logic                  last_pixel;
    } t_sba_out;

    // classified item waiting for the blend stage
    typedef struct packed {
        logic                  write;
        logic                  fast;
        logic [7:0]            k;
        logic [7:0]            inv;
        logic [SBA_WORD_W-1:0] src_word;
        logic [SBA_WORD_W-1:0] dest_word;
        logic [SBA_ADDR_W-1:0] write_address;
        logic [SBA_ADDR_W-1:0] next_src_address;
        logic [SBA_ADDR_W-1:0] next_dest_address;
        logic                  last_pixel;
    } t_sba_job;

    // queue status
    typedef struct packed {
        logic not_empty;
        logic full;
    } t_sba_qstat;

endpackage

[sv/sba_front.sv]
// front end: config registers, rectangle walk, skip runs and blend factors
module sba_front import sba_pkg::*; #(
    parameter int MAX_SPAN = SBA_MAX_SPAN
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [SBA_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SBA_CFG_W-1:0]     i_cfg_data,
    input  logic                     i_in_valid,
    input  t_sba_in                  i_in_data,
    input  t_sba_qstat               i_qstat,
    output logic                     o_in_stall,
    output logic                     o_push,
    output t_sba_job                 o_job
);

    localparam int CNT_W = $clog2(MAX_SPAN + 1);
    localparam int CMP_W = (CNT_W > SBA_SIZE_W) ? CNT_W : SBA_SIZE_W;

    // config registers
    logic [SBA_ALPHA_W-1:0] r_alpha;
    logic [SBA_SIZE_W-1:0]  r_row_pixels;
    logic [SBA_SIZE_W-1:0]  r_row_count;
    logic [SBA_ADDR_W-1:0]  r_dest_start;
    logic [SBA_DSTR_W-1:0]  r_dest_stride;
    logic [SBA_ADDR_W-1:0]  r_src_start;
    logic [SBA_SSTR_W-1:0]  r_src_stride;

    // walk state
    logic                  r_busy;
    logic [SBA_ADDR_W-1:0] r_cur_dst;
    logic [SBA_ADDR_W-1:0] r_cur_src;
    logic [CNT_W-1:0]      r_pix_left;
    logic [SBA_SIZE_W-1:0] r_rows_left;

    logic [CNT_W-1:0]      eff_rp;
    logic [SBA_SIZE_W-1:0] eff_rows;
    logic [SBA_ADDR_W-1:0] w_cur_dst, w_cur_src;
    logic [CNT_W-1:0]      w_pix;
    logic [SBA_SIZE_W-1:0] w_rows;
    logic [CNT_W-1:0]      room, adv;
    logic [SBA_RUN_W-1:0]  run;
    logic                  is_skip, run_ge, row_end, last;
    logic [SBA_ADDR_W-1:0] step_dst, step_src, next_dst, next_src;
    logic [15:0]           k_prod, sa_prod;
    logic [7:0]            sa;

    assign o_in_stall = i_qstat.full;
    assign o_push     = i_in_valid && !i_qstat.full;

    // config write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha       <= SBA_ALPHA_RST;
            r_row_pixels  <= SBA_SIZE_W'(1);
            r_row_count   <= SBA_SIZE_W'(1);
            r_dest_start  <= '0;
            r_dest_stride <= SBA_DSTR_W'(1);
            r_src_start   <= '0;
            r_src_stride  <= SBA_SSTR_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ALPHA_LEVEL: r_alpha       <= i_cfg_data[SBA_ALPHA_W-1:0];
                CFG_ROW_PIXELS:  r_row_pixels  <= i_cfg_data[SBA_SIZE_W-1:0];
                CFG_ROW_COUNT:   r_row_count   <= i_cfg_data[SBA_SIZE_W-1:0];
                CFG_DEST_START:  r_dest_start  <= i_cfg_data[SBA_ADDR_W-1:0];
                CFG_DEST_STRIDE: r_dest_stride <= i_cfg_data[SBA_DSTR_W-1:0];
                CFG_SRC_START:   r_src_start   <= i_cfg_data[SBA_ADDR_W-1:0];
                CFG_SRC_STRIDE:  r_src_stride  <= i_cfg_data[SBA_SSTR_W-1:0];
                default: ;
            endcase
        end
    end

    // row width and row count with zero taken as one, row width clamped to the span limit
    always_comb begin
        if (r_row_pixels == '0) begin
            eff_rp = CNT_W'(1);
        end else if (CMP_W'(r_row_pixels) > CMP_W'(MAX_SPAN)) begin
            eff_rp = CNT_W'(MAX_SPAN);
        end else begin
            eff_rp = CNT_W'(r_row_pixels);
        end
        eff_rows = (r_row_count == '0) ? SBA_SIZE_W'(1) : r_row_count;
    end

    // working values, loaded from the registers at blit start
    assign w_cur_dst = r_busy ? r_cur_dst   : r_dest_start;
    assign w_cur_src = r_busy ? r_cur_src   : r_src_start;
    assign w_pix     = r_busy ? r_pix_left  : eff_rp;
    assign w_rows    = r_busy ? r_rows_left : eff_rows;

    // skip run clamped to the row end
    assign is_skip = (i_in_data.src_word[31:24] == SBA_SKIP_TAG);
    assign run     = i_in_data.src_word[SBA_RUN_W-1:0];
    assign room    = w_pix - CNT_W'(1);
    assign run_ge  = (run >= SBA_RUN_W'(room));
    assign adv     = is_skip ? ((run_ge ? room : CNT_W'(run)) + CNT_W'(1)) : CNT_W'(1);
    assign row_end = (w_pix == CNT_W'(1)) || (is_skip && run_ge);
    assign last    = row_end && (w_rows == SBA_SIZE_W'(1));

    // next addresses: step within a row, step over to the next row, or rewind
    assign step_dst = w_cur_dst + SBA_ADDR_W'(adv);
    assign step_src = w_cur_src + SBA_ADDR_W'(adv);
    always_comb begin
        priority if (!row_end) begin
            next_dst = step_dst;
            next_src = step_src;
        end else if (last) begin
            next_dst = r_dest_start;
            next_src = r_src_start;
        end else begin
            next_dst = step_dst + SBA_ADDR_W'(r_dest_stride) - SBA_ADDR_W'(eff_rp);
            next_src = step_src + SBA_ADDR_W'(r_src_stride) - SBA_ADDR_W'(eff_rp);
        end
    end

    // walk state update per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cur_dst   <= '0;
            r_cur_src   <= '0;
            r_pix_left  <= '0;
            r_rows_left <= '0;
        end else if (o_push) begin
            r_busy      <= !last;
            r_cur_dst   <= next_dst;
            r_cur_src   <= next_src;
            r_pix_left  <= row_end ? eff_rp : (w_pix - adv);
            r_rows_left <= row_end ? (w_rows - SBA_SIZE_W'(1)) : w_rows;
        end
    end

    // q0.8 blend factors for the partial alpha path
    assign k_prod  = 16'(SBA_FULL8) * 16'(r_alpha[7:0]);
    assign sa_prod = 16'(SBA_FULL8 - i_in_data.src_word[31:24]) * 16'(r_alpha[7:0]);
    assign sa      = sa_prod[15:8];

    // classified item
    always_comb begin
        o_job.write             = !is_skip;
        o_job.fast              = r_alpha[SBA_ALPHA_W-1];
        o_job.k                 = k_prod[15:8];
        o_job.inv               = SBA_FULL8 - sa;
        o_job.src_word          = i_in_data.src_word;
        o_job.dest_word         = i_in_data.dest_word;
        o_job.write_address     = w_cur_dst;
        o_job.next_src_address  = next_src;
        o_job.next_dest_address = next_dst;
        o_job.last_pixel        = last;
    end

endmodule

[sv/sba_queue.sv]
// short queue between the front end and the blend stage
module sba_queue import sba_pkg::*; #(
    parameter int DEPTH = SBA_Q_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_sba_job   i_job,
    input  logic       i_pop,
    output t_sba_job   o_job,
    output t_sba_qstat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_sba_job         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assign o_job            = r_mem[r_rd];
    assign o_stat.not_empty = (r_count != '0);
    assign o_stat.full      = (r_count == CNT_W'(DEPTH));

    // fill count stays in range and tracks transfers
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count out of range");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("queue count missed a push");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !i_push) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("queue count missed a pop");

endmodule

[sv/sba_back.sv]
// blend stage: pixel blend and the output register
module sba_back import sba_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_sba_job   i_job,
    input  t_sba_qstat i_qstat,
    input  logic       i_out_stall,
    output logic       o_pop,
    output logic       o_out_valid,
    output t_sba_out   o_out_data
);

    logic                  r_out_valid;
    t_sba_out              r_out;
    logic [23:0]           fast_prod;
    logic [SBA_WORD_W-1:0] fast_sum, fast_px, slow_px, n_data;
    logic [16:0]           ch_sum [3];

    // take the queue head when the output register is free or draining
    assign o_pop = i_qstat.not_empty && (!r_out_valid || !i_out_stall);

    // premultiplied nibble path with wrapping add
    assign fast_prod = i_job.dest_word[27:4] & SBA_NIB_MASK[23:0];
    assign fast_sum  = i_job.src_word + SBA_WORD_W'(fast_prod * i_job.src_word[31:28]);
    assign fast_px   = fast_sum | SBA_OPAQUE;

    // partial alpha path, channel results ORed so carries spill upward
    always_comb begin
        slow_px = SBA_OPAQUE;
        for (int ch = 0; ch < 3; ch++) begin
            ch_sum[ch] = 17'(i_job.k * i_job.src_word[8*ch +: 8])
                       + 17'(i_job.inv * i_job.dest_word[8*ch +: 8]);
            slow_px = slow_px | (SBA_WORD_W'(ch_sum[ch][16:8]) << (8 * ch));
        end
    end

    assign n_data = !i_job.write ? '0 : (i_job.fast ? fast_px : slow_px);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.write_enable      <= i_job.write;
            r_out.write_address     <= i_job.write_address;
            r_out.write_data        <= n_data;
            r_out.next_src_address  <= i_job.next_src_address;
            r_out.next_dest_address <= i_job.next_dest_address;
            r_out.last_pixel        <= i_job.last_pixel;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[sv/sprite_blit_alpha_compositor.sv]
// top level of the sprite blit alpha compositor
//
// Walks a clipped sprite rectangle one pixel per input transfer. Each input
// transfer carries the source word and the destination word at the addresses
// announced by the previous result; the first transfer after idle starts a
// blit at the programmed start addresses. Each input transfer yields exactly
// one result transfer: the write (if any), its address, the blended pixel,
// the next source and destination addresses and a last-pixel flag.
// A source word with top byte 0xFF skips a run of pixels, clamped to the row
// end, and writes nothing.
// Throughput: one item per cycle while the receiver does not stall, set by the
// front end's address and counter update, which finishes one item per cycle.
// Each item is registered in the queue, then in the output register. When the
// receiver stalls, the output register holds, the two-entry queue fills, and
// then o_in_stall rises until the receiver takes a result.
// Reset (synchronous, active low) clears the walk state, empties the queue and
// returns the registers to their reset values. The user must write registers
// through the plain write port while the block is idle; no check enforces it.
module sprite_blit_alpha_compositor import sba_pkg::*; #(
    parameter int MAX_SPAN = SBA_MAX_SPAN,
    parameter int Q_DEPTH  = SBA_Q_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [SBA_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SBA_CFG_W-1:0]     i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_sba_in                  i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_sba_out                 o_out_data
);

    logic       push, pop;
    t_sba_job   front_job, head_job;
    t_sba_qstat qstat;

    // front end: walk and classify
    sba_front #(
        .MAX_SPAN(MAX_SPAN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_qstat    (qstat),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_job      (front_job)
    );

    // decoupling queue
    sba_queue #(
        .DEPTH(Q_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (front_job),
        .i_pop  (pop),
        .o_job  (head_job),
        .o_stat (qstat)
    );

    // blend stage and output register
    sba_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (head_job),
        .i_qstat    (qstat),
        .i_out_stall(i_out_stall),
        .o_pop      (pop),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data)
    );

endmodule
